[rtl/uavrx_pkg.sv]
`default_nettype none
package uavrx_pkg;

  localparam logic [7:0] SyncByte    = 8'h3C;
  localparam logic [7:0] AckType     = 8'h23;
  localparam logic [7:0] AckLenLo    = 8'h08;
  localparam logic [7:0] AckLenHi    = 8'h00;
  localparam logic [7:0] ObjReqType  = 8'h22;
  localparam logic [7:0] TypeFirst   = 8'h20;
  localparam logic [7:0] TypeLastKn  = 8'h24;
  localparam logic [15:0] MinFrameLen = 16'd8;
  localparam logic [15:0] HdrOnlyLen  = 16'd8;
  localparam logic [9:0] MaxBytesRst = 10'd1000;
  localparam logic       AckEnRst    = 1'b1;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCw    = $clog2(FifoDepth + 1);

  localparam logic [3:0] AckLastStep = 4'd9;

  // configuration register indexes (word address)
  typedef enum logic {
    RegMaxBytes = 1'b0,
    RegAckEn    = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    PhHunt    = 4'b0001,
    PhHeader  = 4'b0010,
    PhPayload = 4'b0100,
    PhCrc     = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    CmdPayload   = 2'd0,
    CmdReport    = 2'd1,
    CmdReportAck = 2'd2
  } cmd_kind_e;

  typedef enum logic [1:0] {
    KindPayload = 2'd0,
    KindReport  = 2'd1,
    KindAck     = 2'd2
  } out_kind_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadCrc  = 2'd1,
    StTooLong = 2'd2,
    StBadLen  = 2'd3
  } status_e;

  typedef struct packed {
    logic [9:0] max_bytes;
    logic       ack_en;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic [7:0]  frame_type;
    logic [31:0] object_id;
    logic [15:0] frame_len;
    status_e     status;
  } cmd_t;

  typedef struct packed {
    out_kind_e   kind;
    logic [7:0]  data;
    logic [7:0]  frame_type;
    logic        type_known;
    logic [31:0] object_id;
    logic [15:0] frame_len;
    status_e     status;
    logic        last;
  } res_t;

  // CRC-8, polynomial 0x07, MSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      x = x[7] ? ({x[6:0], 1'b0} ^ 8'h07) : {x[6:0], 1'b0};
    end
    return x;
  endfunction

endpackage
`default_nettype wire

[rtl/uavrx_if.sv]
`default_nettype none
interface uavrx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface uavrx_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  data_byte;
  logic [7:0]  frame_type;
  logic        type_known;
  logic [31:0] object_id;
  logic [15:0] frame_len;
  logic [1:0]  frame_status;
  logic        last;

  modport source(output valid, output out_kind, output data_byte, output frame_type,
                 output type_known, output object_id, output frame_len,
                 output frame_status, output last, input ready);
  modport sink(input valid, input out_kind, input data_byte, input frame_type,
               input type_known, input object_id, input frame_len,
               input frame_status, input last, output ready);
endinterface
`default_nettype wire

[rtl/uavrx_parser.sv]
`default_nettype none
module uavrx_parser
  import uavrx_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       valid_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            ready_o,
  input  wire logic       full_i,
  output logic            push_o,
  output cmd_t            cmd_o
);

  phase_e      phase_q, phase_d;
  logic [9:0]  cnt_q, cnt_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  type_q, type_d;
  logic [31:0] id_q, id_d;

  logic        accept;
  logic [10:0] cnt_nx;
  logic [7:0]  crc_nx;
  cmd_kind_e   kind;
  status_e     status;
  logic [7:0]  data;

  assign ready_o = !full_i;
  assign accept  = valid_i && !full_i;
  assign cnt_nx  = {1'b0, cnt_q} + 11'd1;
  assign crc_nx  = crc8_byte(crc_q, rx_byte_i);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    crc_d   = crc_q;
    type_d  = type_q;
    id_d    = id_q;
    push_o  = 1'b0;
    kind    = CmdReport;
    status  = StOk;
    data    = 8'h00;
    if (accept) begin
      unique case (phase_q)
        PhHunt: begin
          if (rx_byte_i == SyncByte) begin
            type_d = 8'h00;
            id_d   = 32'h0;
            len_d  = 16'h0;
            crc_d  = crc8_byte(8'h00, rx_byte_i);
            cnt_d  = 10'd1;
            if (cfg_i.max_bytes == 10'd0) begin
              push_o = 1'b1;
              status = StTooLong;
            end else begin
              phase_d = PhHeader;
            end
          end
        end
        PhHeader, PhPayload, PhCrc: begin
          if (cnt_nx > {1'b0, cfg_i.max_bytes}) begin
            // drop the byte, abort the frame
            phase_d = PhHunt;
            push_o  = 1'b1;
            status  = StTooLong;
          end else begin
            cnt_d = cnt_nx[9:0];
            priority if (phase_q == PhHeader) begin
              crc_d = crc_nx;
              priority if (cnt_q == 10'd1) begin
                type_d = rx_byte_i;
              end else if (cnt_q == 10'd2) begin
                len_d = {8'h00, rx_byte_i};
              end else if (cnt_q == 10'd3) begin
                len_d = {rx_byte_i, len_q[7:0]};
                if ({rx_byte_i, len_q[7:0]} < MinFrameLen) begin
                  phase_d = PhHunt;
                  push_o  = 1'b1;
                  status  = StBadLen;
                end
              end else if (cnt_q >= 10'd4 && cnt_q <= 10'd7) begin
                id_d[{cnt_q[1:0], 3'b000} +: 8] = rx_byte_i;
                if (cnt_q == 10'd7) begin
                  phase_d = (len_q == HdrOnlyLen) ? PhCrc : PhPayload;
                end
              end else begin
                phase_d = PhHunt;
              end
            end else if (phase_q == PhPayload) begin
              crc_d  = crc_nx;
              push_o = 1'b1;
              kind   = CmdPayload;
              data   = rx_byte_i;
              if ({5'b0, cnt_nx} == len_q) begin
                phase_d = PhCrc;
              end
            end else begin
              phase_d = PhHunt;
              push_o  = 1'b1;
              if (rx_byte_i == crc_q) begin
                status = StOk;
                kind   = (type_q == ObjReqType && cfg_i.ack_en) ? CmdReportAck : CmdReport;
              end else begin
                status = StBadCrc;
              end
            end
          end
        end
        default: phase_d = PhHunt;
      endcase
    end
  end

  always_comb begin
    cmd_o.kind       = kind;
    cmd_o.data       = data;
    cmd_o.frame_type = type_d;
    cmd_o.object_id  = id_d;
    cmd_o.frame_len  = len_d;
    cmd_o.status     = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      cnt_q   <= 10'd0;
      len_q   <= 16'h0;
      crc_q   <= 8'h00;
      type_q  <= 8'h00;
      id_q    <= 32'h0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      crc_q   <= crc_d;
      type_q  <= type_d;
      id_q    <= id_d;
    end
  end

endmodule
`default_nettype wire

[rtl/uavrx_cmd_fifo.sv]
`default_nettype none
module uavrx_cmd_fifo
  import uavrx_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      cmd_o,
  output logic      empty_o
);

  cmd_t              mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_q, wr_d;
  logic [FifoAw-1:0] rd_q, rd_d;
  logic [FifoCw-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == FifoCw'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

[rtl/uavrx_emitter.sv]
`default_nettype none
module uavrx_emitter
  import uavrx_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cmd_t cmd_i,
  input  wire logic empty_i,
  output logic      pop_o,
  output logic      valid_o,
  input  wire logic ready_i,
  output res_t      res_o
);

  logic [3:0] step_q, step_d;
  logic [7:0] crc_q, crc_d;
  logic       out_valid_q, out_valid_d;
  res_t       out_q;
  res_t       res;
  logic       load;
  logic [7:0] ack_byte;

  assign load = !empty_i && (!out_valid_q || ready_i);

  // acknowledge frame bytes, step 1 onwards
  always_comb begin
    unique case (step_q)
      4'd1:    ack_byte = SyncByte;
      4'd2:    ack_byte = AckType;
      4'd3:    ack_byte = AckLenLo;
      4'd4:    ack_byte = AckLenHi;
      4'd5:    ack_byte = cmd_i.object_id[7:0];
      4'd6:    ack_byte = cmd_i.object_id[15:8];
      4'd7:    ack_byte = cmd_i.object_id[23:16];
      4'd8:    ack_byte = cmd_i.object_id[31:24];
      4'd9:    ack_byte = crc_q;
      default: ack_byte = 8'h00;
    endcase
  end

  always_comb begin
    res.frame_type = cmd_i.frame_type;
    res.type_known = (cmd_i.frame_type >= TypeFirst) && (cmd_i.frame_type <= TypeLastKn);
    res.object_id  = cmd_i.object_id;
    res.frame_len  = cmd_i.frame_len;
    if (step_q == 4'd0) begin
      res.kind   = (cmd_i.kind == CmdPayload) ? KindPayload : KindReport;
      res.data   = cmd_i.data;
      res.status = cmd_i.status;
      res.last   = (cmd_i.kind != CmdReportAck);
    end else begin
      res.kind   = KindAck;
      res.data   = ack_byte;
      res.status = StOk;
      res.last   = (step_q == AckLastStep);
    end
  end

  always_comb begin
    pop_o  = 1'b0;
    step_d = step_q;
    crc_d  = crc_q;
    if (load) begin
      if (res.last) begin
        pop_o  = 1'b1;
        step_d = 4'd0;
        crc_d  = 8'h00;
      end else begin
        step_d = step_q + 4'd1;
        crc_d  = (step_q == 4'd0) ? 8'h00 : crc8_byte(crc_q, ack_byte);
      end
    end
    out_valid_d = load ? 1'b1 : (out_valid_q && !ready_i);
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 4'd0;
      crc_q       <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign valid_o = out_valid_q;
  assign res_o   = out_q;

endmodule
`default_nettype wire

[rtl/uavtalk_frame_receiver_unit.sv]
`default_nettype none
// Frame receiver for a UAVTalk-style link. Link bytes enter one per word on in_i; the
// receiver hunts for sync 0x3C, collects type, 16-bit length and 32-bit object id, and
// passes each payload byte on out_o as it arrives (out_kind 0). At frame end it sends one
// report word (out_kind 1) with status ok, bad CRC, too long or bad length; a good type
// 0x22 frame with ack_enable set is followed by the nine bytes of an acknowledge frame
// (out_kind 2). The last flag marks the final word caused by one input byte. Rate: one
// input byte per cycle while the queue is not full; each result passes the command queue
// and the output register, which passes one word per cycle while out_o.ready is high,
// so a report with acknowledge holds it for ten words; a four-entry command queue
// between parser and emitter absorbs that, and in_i.ready falls only when the queue is
// full. Registers sit on an APB port: max_frame_bytes at 0x0 (bits 9:0, reset 1000),
// ack_enable at 0x4 (bit 0, reset 1); write them only while the receiver is idle.
module uavtalk_frame_receiver_unit
  import uavrx_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  uavrx_in_if.sink         in_i,
  uavrx_out_if.source      out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t cfg_q, cfg_d;
  logic cfg_wr;
  reg_idx_e reg_idx;

  cmd_t push_cmd, head_cmd;
  logic push, full, pop, empty;
  res_t res;

  // Configuration: word index in paddr[2], byte offset ignored.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        RegMaxBytes: cfg_d.max_bytes = pwdata[9:0];
        RegAckEn:    cfg_d.ack_en    = pwdata[0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegMaxBytes: prdata = {22'h0, cfg_q.max_bytes};
      RegAckEn:    prdata = {31'h0, cfg_q.ack_en};
      default:     prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_bytes <= MaxBytesRst;
      cfg_q.ack_en    <= AckEnRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: classify each byte, push one command per byte that has results.
  uavrx_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .valid_i   (in_i.valid),
    .rx_byte_i (in_i.rx_byte),
    .ready_o   (in_i.ready),
    .full_i    (full),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  uavrx_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (empty)
  );

  // Back: expand each command into its result words.
  uavrx_emitter u_emitter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (head_cmd),
    .empty_i (empty),
    .pop_o   (pop),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res)
  );

  assign out_o.out_kind     = res.kind;
  assign out_o.data_byte    = res.data;
  assign out_o.frame_type   = res.frame_type;
  assign out_o.type_known   = res.type_known;
  assign out_o.object_id    = res.object_id;
  assign out_o.frame_len    = res.frame_len;
  assign out_o.frame_status = res.status;
  assign out_o.last         = res.last;

endmodule
`default_nettype wire
